// ===== rtl/core/tbes_pkg.sv =====
// Package for the timer bank with earliest select.
// Holds operation codes, sequencer states and payload widths; no dependencies.
`default_nettype none

package tbes_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned REM_W   = 26;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 32;
  localparam logic [REM_W-1:0] REM_MAX = {REM_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_SET      = 3'd0,
    OP_KILL     = 3'd1,
    OP_KILL_ALL = 3'd2,
    OP_TICK     = 3'd3,
    OP_QUERY    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_LOAD,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/timer_bank_with_earliest_select.sv =====
// Timer bank with earliest select: top level, sequencer, count memory and scan unit.
// Depends on tbes_pkg.
// The scan reads, decrements and compares one count per cycle through the memory read
// port and writes decremented counts back through the separate write port. A new item
// is accepted only in the idle state, after the previous result is in the output register.
// Reset: synchronous; clears the sequencer, the output valid and all enable flags.
// Counts are not cleared; a count is always loaded by set in the same cycle as its timer is enabled.
`default_nettype none

module timer_bank_with_earliest_select
  import tbes_pkg::*;
#(
  parameter int unsigned NUM_TIMERS       = 8,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // operation[2:0], timer_index[5:3], duration_seconds[21:6], zero pad
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // next_valid[0], next_timer[3:1], next_remaining[29:4],
  // indexed_enabled[30], indexed_expired[31]
  output logic [OUT_W-1:0]      m_tdata
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PW = DUR_W + TW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_TIMERS - 1);

  state_t state, state_next;

  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] idx_q;
  logic [DUR_W-1:0] dur_q;
  logic [PW-1:0]    prod;

  logic [NUM_TIMERS-1:0] enabled;
  logic [REM_W-1:0]      mem [NUM_TIMERS];
  logic [REM_W-1:0]      rd_data;
  logic [AW-1:0]         rd_ptr;
  logic [AW-1:0]         pr_addr;
  logic                  pr_valid;

  logic             found;
  logic             done;
  logic [AW-1:0]    best;
  logic [REM_W-1:0] best_rem;
  logic             idx_zero;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REM_W-1:0] wr_data;

  logic             idx_ok;
  logic [AW-1:0]    idx_addr;
  logic             is_set;
  logic             is_tick;
  logic             pr_en;
  logic             pr_dec;
  logic [REM_W-1:0] pr_val;
  logic [REM_W-1:0] load_val;
  logic             s_accept;
  logic             out_load;

  assign idx_ok   = 32'(idx_q) < NUM_TIMERS;
  assign idx_addr = AW'(idx_q);
  assign is_set   = (op_q == OP_SET);
  assign is_tick  = (op_q == OP_TICK);
  assign pr_en    = enabled[pr_addr];
  assign pr_dec   = is_tick && pr_en && (rd_data != '0);
  assign pr_val   = pr_dec ? (rd_data - REM_W'(1)) : rd_data;
  assign load_val = (prod > PW'(REM_MAX)) ? REM_MAX : REM_W'(prod);
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_accept) state_next = S_APPLY;
      S_APPLY: state_next = S_LOAD;
      S_LOAD:  state_next = S_SCAN;
      S_SCAN:  if (rd_ptr == LAST_ADDR) state_next = S_LAST;
      S_LAST:  state_next = S_DONE;
      S_DONE:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pr_addr;
    wr_data  = pr_val;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_LOAD: begin
        wr_en   = is_set && idx_ok;
        wr_addr = idx_addr;
        wr_data = load_val;
      end
      S_SCAN, S_LAST: wr_en = pr_valid && pr_dec;
      S_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_q  <= s_tdata[OP_W-1:0];
      idx_q <= s_tdata[OP_W+IDX_W-1:OP_W];
      dur_q <= s_tdata[OP_W+IDX_W+DUR_W-1:OP_W+IDX_W];
    end
    if (state == S_APPLY) begin
      prod <= PW'(dur_q) * PW'(TICKS_PER_SECOND);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else if (state == S_APPLY) begin
      unique case (op_q)
        OP_KILL:     if (idx_ok) enabled[idx_addr] <= 1'b0;
        OP_KILL_ALL: enabled <= '0;
        default: ;
      endcase
    end else if (state == S_LOAD && is_set && idx_ok) begin
      enabled[idx_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else begin
      pr_valid <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    pr_addr <= rd_ptr;
    if (state == S_LOAD) begin
      rd_ptr   <= '0;
      found    <= 1'b0;
      done     <= 1'b0;
      best     <= '0;
      best_rem <= '0;
      idx_zero <= 1'b0;
    end else begin
      if (state == S_SCAN && rd_ptr != LAST_ADDR) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (pr_valid) begin
        if (pr_addr == idx_addr) begin
          idx_zero <= (pr_val == '0);
        end
        if (pr_en && !done) begin
          if (pr_val == '0) begin
            found    <= 1'b1;
            done     <= 1'b1;
            best     <= pr_addr;
            best_rem <= '0;
          end else if (!found || pr_val < best_rem) begin
            found    <= 1'b1;
            best     <= pr_addr;
            best_rem <= pr_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[0]    <= found;
      m_tdata[3:1]  <= found ? 3'(best) : 3'd0;
      m_tdata[29:4] <= found ? best_rem : '0;
      m_tdata[30]   <= idx_ok && enabled[idx_addr];
      m_tdata[31]   <= idx_ok && enabled[idx_addr] && idx_zero;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for timer_bank_with_earliest_select: directed and random timer items
// with a scoreboard class that predicts each next-timer report. Depends on tbes_pkg.
module tb_top;
  import tbes_pkg::*;

  localparam int unsigned NUM_TIMERS  = 8;
  localparam int unsigned TICKS       = 1000;
  localparam int unsigned RAND_ITEMS  = 600;
  localparam int unsigned LATENCY     = NUM_TIMERS + 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic             indexed_expired;
    logic             indexed_enabled;
    logic [REM_W-1:0] next_remaining;
    logic [2:0]       next_timer;
    logic             next_valid;
  } report_t;

  class next_timer_board;
    bit               enabled [NUM_TIMERS];
    logic [REM_W-1:0] remaining [NUM_TIMERS];
    report_t          predicted_reports [$];
    int unsigned      errors;

    function new();
      foreach (enabled[i]) begin
        enabled[i]   = 1'b0;
        remaining[i] = '0;
      end
      errors = 0;
    endfunction

    function void note_item(logic [2:0] op, logic [2:0] idx, logic [15:0] dur);
      longint unsigned load;
      bit              in_bank;
      bit              found;
      bit              hit_zero;
      report_t         r;
      in_bank  = idx < NUM_TIMERS;
      found    = 1'b0;
      hit_zero = 1'b0;
      r        = '0;
      case (op_t'(op))
        OP_SET: begin
          if (in_bank) begin
            load           = longint'(dur) * TICKS;
            enabled[idx]   = 1'b1;
            remaining[idx] = (load > REM_MAX) ? REM_MAX : load[REM_W-1:0];
          end
        end
        OP_KILL: begin
          if (in_bank) enabled[idx] = 1'b0;
        end
        OP_KILL_ALL: begin
          foreach (enabled[i]) enabled[i] = 1'b0;
        end
        OP_TICK: begin
          foreach (enabled[i])
            if (enabled[i] && remaining[i] != 0) remaining[i] = remaining[i] - 1'b1;
        end
        default: ;
      endcase
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (enabled[i] && !hit_zero) begin
          if (remaining[i] == 0) begin
            hit_zero         = 1'b1;
            found            = 1'b1;
            r.next_timer     = 3'(i);
            r.next_remaining = '0;
          end else if (!found || remaining[i] < r.next_remaining) begin
            found            = 1'b1;
            r.next_timer     = 3'(i);
            r.next_remaining = remaining[i];
          end
        end
      end
      r.next_valid = found;
      if (in_bank) begin
        r.indexed_enabled = enabled[idx];
        r.indexed_expired = enabled[idx] && remaining[idx] == 0;
      end
      predicted_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      report_t want;
      report_t got;
      got = data;
      if (predicted_reports.size() == 0) begin
        $error("result with no pending item: m_tdata %h", data);
        errors++;
      end else begin
        want = predicted_reports.pop_front();
        compare_field("next_valid", 32'(want.next_valid), 32'(got.next_valid));
        compare_field("next_timer", 32'(want.next_timer), 32'(got.next_timer));
        compare_field("next_remaining", 32'(want.next_remaining),
                      32'(got.next_remaining));
        compare_field("indexed_enabled", 32'(want.indexed_enabled),
                      32'(got.indexed_enabled));
        compare_field("indexed_expired", 32'(want.indexed_expired),
                      32'(got.indexed_expired));
      end
    endfunction

    function int unsigned pending();
      return predicted_reports.size();
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata;
  logic            m_tvalid;
  logic            m_tready;
  logic [OUT_W-1:0] m_tdata;

  next_timer_board board;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_request;
  bit              hold_done;
  int unsigned     hold_left;
  int unsigned     cycle_count;

  timer_bank_with_earliest_select #(
    .NUM_TIMERS(NUM_TIMERS),
    .TICKS_PER_SECOND(TICKS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [2:0] idx,
                           input logic [15:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {2'b00, dur, idx, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_item(op, idx, dur);
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned pick;
    int unsigned dpick;
    logic [2:0]  op;
    logic [15:0] dur;
    pick  = $urandom_range(99);
    dpick = $urandom_range(99);
    if (pick < 28)      op = OP_SET;
    else if (pick < 40) op = OP_KILL;
    else if (pick < 44) op = OP_KILL_ALL;
    else if (pick < 82) op = OP_TICK;
    else if (pick < 92) op = OP_QUERY;
    else                op = 3'($urandom_range(5, 7));
    if (dpick < 35)      dur = 16'd0;
    else if (dpick < 65) dur = 16'($urandom_range(1, 3));
    else if (dpick < 90) dur = 16'($urandom_range(0, 15));
    else                 dur = 16'($urandom);
    send_item(op, 3'($urandom_range(7)), dur);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  initial begin
    board         = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    hold_request  = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 50;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(OP_QUERY, 3'd0, 16'd0);
    send_item(3'd5, 3'd1, 16'hFFFF);
    send_item(3'd6, 3'd2, 16'd0);
    send_item(3'd7, 3'd7, 16'h5555);
    send_item(OP_SET, 3'd7, 16'hFFFF);
    send_item(OP_SET, 3'd0, 16'd0);
    send_item(OP_QUERY, 3'd0, 16'd0);
    send_item(OP_SET, 3'd3, 16'd1);
    send_item(OP_KILL, 3'd0, 16'd0);
    send_item(OP_TICK, 3'd3, 16'd0);
    send_item(OP_SET, 3'd4, 16'd1);
    send_item(OP_SET, 3'd2, 16'd1);
    send_item(OP_KILL, 3'd3, 16'd0);
    send_item(OP_TICK, 3'd0, 16'd0);
    send_item(OP_QUERY, 3'd0, 16'd0);
    send_item(OP_SET, 3'd0, 16'd3);
    send_item(OP_SET, 3'd1, 16'hAAAA);
    send_item(OP_SET, 3'd6, 16'h5555);
    send_item(OP_KILL_ALL, 3'd6, 16'd0);
    send_item(OP_TICK, 3'd6, 16'd0);
    send_item(OP_QUERY, 3'd1, 16'd0);
    send_item(OP_SET, 3'd5, 16'd0);
    send_item(OP_TICK, 3'd5, 16'd0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 35;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 3 * RAND_ITEMS / 4) hold_request = 1'b1;
      send_random();
    end
    s_tvalid = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
